FILE: sv/sgpa_pkg.sv
// Shared types, widths and constants of the streaming graph partition block.
`timescale 1ns / 1ps
package sgpa_pkg;

    localparam int VID_W    = 16;   // vertex index field
    localparam int DEG_W    = 16;   // degree field
    localparam int PC_W     = 5;    // partition code in table and results
    localparam int SCORE_W  = 16;
    localparam int SIZE_W   = 17;
    localparam int COST_W   = 17;
    localparam int ALPHA_W  = 24;
    localparam int LFSR_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IX_W = 2;

    localparam int M_W        = SIZE_W + 1;       // m = 2L or 2L+1
    localparam int SQRT_SHIFT = 43;
    localparam int V_W        = 62;               // radicand width, even
    localparam int ROOT_W     = 31;
    localparam int PROD_W     = M_W + ROOT_W;
    localparam int D_W        = 34;               // penalty difference
    localparam int DH_W       = 17;               // half of D_W
    localparam int PL_W       = ALPHA_W + DH_W;
    localparam int FULL_W     = PL_W + DH_W + 1;
    localparam int DCQ_SHIFT  = 23;
    localparam int DCQ_W      = FULL_W - DCQ_SHIFT;
    localparam int Q_W        = DCQ_W + 2;
    localparam int MAGQ_W     = Q_W - 16;

    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;
    localparam int QC_W   = 3;

    localparam logic [PC_W-1:0]     UNASSIGNED = 5'd17;
    localparam logic [SCORE_W-1:0]  SCORE_MAX  = 16'hFFFF;
    localparam logic [SIZE_W-1:0]   SIZE_MAX   = 17'h1FFFF;
    localparam logic [LFSR_W-1:0]   LFSR_MASK  = 16'hB400;
    localparam logic signed [COST_W-1:0] COST_MAX = 17'sd65535;
    localparam logic signed [COST_W-1:0] COST_MIN = -17'sd65536;
    localparam logic [MAGQ_W-1:0]   MAGQ_POS_LIM = 22'd65535;
    localparam logic [MAGQ_W-1:0]   MAGQ_NEG_LIM = 22'd65536;

    localparam logic [CFG_IX_W-1:0] CFG_NUM_PARTS     = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_DEGREE_CUTOFF = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_BALANCE_ALPHA = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_RANDOM_SEED   = 2'd3;

    typedef struct packed {
        logic [VID_W-1:0] vertex_index;
        logic [DEG_W-1:0] vertex_degree;
        logic [VID_W-1:0] neighbor_index;
        logic             neighbor_valid;
        logic             last_of_vertex;
    } item_t;

    typedef struct packed {
        logic [PC_W-1:0]    np;
        logic [DEG_W-1:0]   degree_cutoff;
        logic [ALPHA_W-1:0] alpha;
        logic               lfsr_load;
        logic [LFSR_W-1:0]  lfsr_seed;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_NB_RD, ST_NB_UPD, ST_VX_RD, ST_VX_SEL, ST_LFSR_MUL,
        ST_SQ0_GO, ST_SQ0_WAIT, ST_SQ1_GO, ST_SQ1_WAIT, ST_MUL0, ST_MUL1,
        ST_DIFF, ST_PLO, ST_PHI, ST_DCQ, ST_Q, ST_CMP, ST_SIZE_DEC,
        ST_SIZE_INC, ST_EMIT
    } bstate_t;

endpackage

FILE: sv/sgpa_front.sv
// Front end: accepts items, drops header-only items, queues the rest.
`timescale 1ns / 1ps
module sgpa_front import sgpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        clear_busy,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t            mem [QDEPTH];
    logic [QA_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]  cnt_reg, cnt_next;
    logic             push, pop;
    item_t            in_item;

    assign s_tready = !clear_busy && (cnt_reg != QC_W'(QDEPTH));
    // items with neither a neighbor nor the last flag change nothing
    assign push     = s_tvalid && s_tready && (s_tuser || s_tlast);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rd_ptr_reg];

    always_comb begin
        in_item.vertex_index   = s_tdata[15:0];
        in_item.vertex_degree  = s_tdata[31:16];
        in_item.neighbor_index = s_tdata[47:32];
        in_item.neighbor_valid = s_tuser;
        in_item.last_of_vertex = s_tlast;
        cnt_next = cnt_reg + QC_W'(push) - QC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/sgpa_isqrt.sv
// Bit-serial integer square root of m << 43, one result bit per cycle.
`timescale 1ns / 1ps
module sgpa_isqrt import sgpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [M_W-1:0]    m_in,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [V_W-1:0] v_reg, r_reg, b_reg, t;
    logic           busy_reg, done_reg, ge;

    assign t    = r_reg + b_reg;
    assign ge   = (v_reg >= t);
    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= V_W'({m_in, {SQRT_SHIFT{1'b0}}});
            r_reg <= '0;
            b_reg <= V_W'(1) << (V_W - 2);
        end else if (busy_reg) begin
            if (ge) begin
                v_reg <= v_reg - t;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (b_reg == V_W'(1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

FILE: sv/sgpa_back.sv
// Back end: partition table, sizes, scores, placement sequencer, result register.
`timescale 1ns / 1ps
module sgpa_back import sgpa_pkg::*; #(
    parameter int MAX_VERTICES = 65536,
    parameter int MAX_PARTS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        clear_busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int IDX_W = $clog2(MAX_PARTS);

    bstate_t state_reg, state_next;

    logic [PC_W-1:0]    tbl_mem [MAX_VERTICES];
    logic [PC_W-1:0]    tbl_rdata_reg, tbl_wdata;
    logic [VA_W-1:0]    tbl_raddr, tbl_waddr, clr_cnt_reg;
    logic               tbl_rd_en, tbl_we;

    logic [SCORE_W-1:0] score_reg [MAX_PARTS];
    logic [SIZE_W-1:0]  size_reg  [MAX_PARTS];
    logic [IDX_W-1:0]   sc_idx, sz_idx;
    logic [SCORE_W-1:0] sc_rd;
    logic [SIZE_W-1:0]  sz_rd;

    logic [VA_W-1:0]    vidx_reg, nidx_reg;
    logic [DEG_W-1:0]   degree_reg;
    logic               last_reg, first_reg;
    logic [PC_W-1:0]    oldp_reg, newp_reg, walk_reg;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_step;
    logic signed [COST_W-1:0] best_reg, cost_c;

    logic               sq_start, sq_done;
    logic [M_W-1:0]     sq_m, m0_reg;
    logic [ROOT_W-1:0]  sq_root, s0_reg, s1_reg;
    logic [PROD_W-1:0]  prod0_reg, prod1_reg;
    logic [D_W-1:0]     d_reg;
    logic [PL_W-1:0]    plo_reg, phi_reg;
    logic [FULL_W-1:0]  full_sum;
    logic [DCQ_W-1:0]   dcq_reg;
    logic signed [DEG_W:0]  diff_s;
    logic signed [Q_W-1:0]  q_next, q_reg;
    logic [Q_W-1:0]     mag;
    logic [MAGQ_W-1:0]  magq;
    logic [LFSR_W+PC_W-1:0] rnd_prod;

    logic               emit_load;
    logic               out_valid_reg;
    logic [VID_W-1:0]   out_vid_reg;
    logic [PC_W-1:0]    out_part_reg, out_prev_reg;
    logic signed [COST_W-1:0] out_cost_reg;

    sgpa_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .m_in    (sq_m),
        .done    (sq_done),
        .root    (sq_root)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_cnt_reg == VA_W'(MAX_VERTICES - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.neighbor_valid) state_next = ST_NB_RD;
                    else                       state_next = ST_VX_RD;
                end
            end
            ST_NB_RD:    state_next = ST_NB_UPD;
            ST_NB_UPD:   state_next = last_reg ? ST_VX_RD : ST_IDLE;
            ST_VX_RD:    state_next = ST_VX_SEL;
            ST_VX_SEL: begin
                if (degree_reg >= cfg.degree_cutoff) state_next = ST_SIZE_DEC;
                else if (degree_reg == '0)           state_next = ST_LFSR_MUL;
                else                                 state_next = ST_SQ0_GO;
            end
            ST_LFSR_MUL: state_next = ST_SIZE_DEC;
            ST_SQ0_GO:   state_next = ST_SQ0_WAIT;
            ST_SQ0_WAIT: if (sq_done) state_next = ST_SQ1_GO;
            ST_SQ1_GO:   state_next = ST_SQ1_WAIT;
            ST_SQ1_WAIT: if (sq_done) state_next = ST_MUL0;
            ST_MUL0:     state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_PLO;
            ST_PLO:      state_next = ST_PHI;
            ST_PHI:      state_next = ST_DCQ;
            ST_DCQ:      state_next = ST_Q;
            ST_Q:        state_next = ST_CMP;
            ST_CMP:      state_next = (walk_reg == '0) ? ST_SIZE_DEC : ST_SQ0_GO;
            ST_SIZE_DEC: state_next = ST_SIZE_INC;
            ST_SIZE_INC: state_next = ST_EMIT;
            ST_EMIT:     if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        q_ready    = (state_reg == ST_IDLE);
        clear_busy = (state_reg == ST_CLEAR);
        tbl_rd_en  = (state_reg == ST_NB_RD) || (state_reg == ST_VX_RD);
        tbl_raddr  = (state_reg == ST_NB_RD) ? nidx_reg : vidx_reg;
        tbl_we     = (state_reg == ST_CLEAR) || (state_reg == ST_SIZE_DEC);
        tbl_waddr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : vidx_reg;
        tbl_wdata  = (state_reg == ST_CLEAR) ? UNASSIGNED : newp_reg;
        sq_start   = (state_reg == ST_SQ0_GO) || (state_reg == ST_SQ1_GO);
        emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
        case (state_reg)
            ST_NB_UPD:   sc_idx = IDX_W'(tbl_rdata_reg);
            default:     sc_idx = IDX_W'(walk_reg);
        endcase
        case (state_reg)
            ST_SIZE_DEC: sz_idx = IDX_W'(oldp_reg);
            ST_SIZE_INC: sz_idx = IDX_W'(newp_reg);
            default:     sz_idx = IDX_W'(walk_reg);
        endcase
    end

    // datapath helpers
    always_comb begin
        sc_rd = score_reg[sc_idx];
        sz_rd = size_reg[sz_idx];
        sq_m  = (state_reg == ST_SQ0_GO) ? {sz_rd, 1'b0} : (m0_reg | M_W'(1));
        lfsr_step = lfsr_reg >> 1;
        if (lfsr_reg[0]) lfsr_step = lfsr_step ^ LFSR_MASK;
        rnd_prod  = lfsr_reg * cfg.np;
        full_sum  = (FULL_W'(phi_reg) << DH_W) + FULL_W'(plo_reg);
        diff_s    = $signed({1'b0, sc_rd}) - $signed({1'b0, degree_reg});
        q_next    = (Q_W'(diff_s) <<< 16) - $signed({1'b0, dcq_reg});
        // truncate toward zero, then saturate
        mag  = q_reg[Q_W-1] ? Q_W'(-q_reg) : Q_W'(q_reg);
        magq = mag[Q_W-1:16];
        if (!q_reg[Q_W-1]) begin
            cost_c = (magq > MAGQ_POS_LIM) ? COST_MAX : $signed({1'b0, magq[15:0]});
        end else begin
            cost_c = (magq > MAGQ_NEG_LIM) ? COST_MIN : -$signed(magq[COST_W-1:0]);
        end
    end

    // partition table memory
    always_ff @(posedge aclk) begin
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
        if (tbl_rd_en) tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                vidx_reg   <= VA_W'(q_item.vertex_index % MAX_VERTICES);
                nidx_reg   <= VA_W'(q_item.neighbor_index % MAX_VERTICES);
                degree_reg <= q_item.vertex_degree;
                last_reg   <= q_item.last_of_vertex;
            end
            ST_VX_SEL: begin
                oldp_reg  <= tbl_rdata_reg;
                best_reg  <= '0;
                newp_reg  <= cfg.np;
                walk_reg  <= cfg.np - 1'b1;
                first_reg <= 1'b1;
            end
            ST_LFSR_MUL: newp_reg <= PC_W'(rnd_prod >> LFSR_W);
            ST_SQ0_GO:   m0_reg   <= sq_m;
            ST_SQ0_WAIT: s0_reg   <= sq_root;
            ST_SQ1_WAIT: s1_reg   <= sq_root;
            ST_MUL0:     prod0_reg <= m0_reg * s0_reg;
            ST_MUL1:     prod1_reg <= (m0_reg | M_W'(1)) * s1_reg;
            ST_DIFF:     d_reg    <= D_W'(prod1_reg - prod0_reg);
            ST_PLO:      plo_reg  <= cfg.alpha * d_reg[DH_W-1:0];
            ST_PHI:      phi_reg  <= cfg.alpha * d_reg[D_W-1:DH_W];
            ST_DCQ:      dcq_reg  <= full_sum[FULL_W-1:DCQ_SHIFT];
            ST_Q:        q_reg    <= q_next;
            ST_CMP: begin
                // walk goes downward, so a tie keeps the higher index
                if (first_reg || (cost_c > best_reg)) begin
                    best_reg <= cost_c;
                    newp_reg <= walk_reg;
                end
                first_reg <= 1'b0;
                if (walk_reg != '0) walk_reg <= walk_reg - 1'b1;
            end
            default: ;
        endcase
        if (emit_load) begin
            out_vid_reg  <= VID_W'(vidx_reg);
            out_part_reg <= newp_reg;
            out_prev_reg <= oldp_reg;
            out_cost_reg <= best_reg;
        end
    end

    // control state, sizes, scores, LFSR
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            lfsr_reg      <= LFSR_W'(1);
            for (int i = 0; i < MAX_PARTS; i++) begin
                score_reg[i] <= '0;
                size_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (emit_load)     out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            if (cfg.lfsr_load) begin
                lfsr_reg <= (cfg.lfsr_seed == '0) ? LFSR_W'(1) : cfg.lfsr_seed;
            end else if ((state_reg == ST_VX_SEL) && (degree_reg < cfg.degree_cutoff)
                         && (degree_reg == '0)) begin
                lfsr_reg <= lfsr_step;
            end

            case (state_reg)
                ST_NB_UPD: begin
                    if ((tbl_rdata_reg < cfg.np) && (sc_rd != SCORE_MAX))
                        score_reg[sc_idx] <= sc_rd + 1'b1;
                end
                ST_SIZE_DEC: begin
                    if ((oldp_reg < cfg.np) && (sz_rd != '0))
                        size_reg[sz_idx] <= sz_rd - 1'b1;
                end
                ST_SIZE_INC: begin
                    if ((newp_reg < cfg.np) && (sz_rd != SIZE_MAX))
                        size_reg[sz_idx] <= sz_rd + 1'b1;
                    for (int i = 0; i < MAX_PARTS; i++) score_reg[i] <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cost_reg, out_prev_reg, out_part_reg, out_vid_reg};

    a_nb_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NB_UPD) |-> ($past(state_reg) == ST_NB_RD))
        else $error("score update without table read");
    a_sq_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == ST_SQ0_WAIT || state_reg == ST_SQ1_WAIT))
        else $error("square root finished outside a wait state");
    a_walk_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ0_GO) |-> (walk_reg < cfg.np))
        else $error("walk index out of range");
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded");

endmodule

FILE: sv/streaming_graph_partition_assign.sv
// Top level: configuration registers, front end and back end of the partitioner.
// Neighbor item: the back end reads the table, then updates the score.
// Placement (last item): for degree 1..cutoff-1, every partition in use is scored in turn,
// running the bit-serial square root twice for each.
// Results leave through an output register; up to 4 items queue in front.
// Reset (aresetn low, synchronous) clears sizes, scores and config to defaults,
// then a clearing pass fills all MAX_VERTICES table entries; no item is taken.
`timescale 1ns / 1ps
module streaming_graph_partition_assign import sgpa_pkg::*; #(
    parameter int MAX_VERTICES = 65536,
    parameter int MAX_PARTS    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config write port
    input  logic                cfg_wr_en,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,  // vertex_index, vertex_degree, neighbor_index
    input  logic                s_tuser,  // neighbor_valid
    input  logic                s_tlast,  // last_of_vertex
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata   // placed_vertex, assigned_part,
                                          // previous_part, best_cost, zero pad
);

    logic [PC_W-1:0]    num_parts_reg;
    logic [DEG_W-1:0]   cutoff_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    cfg_t               cfg;
    logic               clear_busy, q_valid, q_ready;
    item_t              q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parts_reg <= 5'd2;
            cutoff_reg    <= 16'd50;
            alpha_reg     <= 24'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_PARTS:     num_parts_reg <= cfg_wdata[PC_W-1:0];
                CFG_DEGREE_CUTOFF: cutoff_reg    <= cfg_wdata[DEG_W-1:0];
                CFG_BALANCE_ALPHA: alpha_reg     <= cfg_wdata[ALPHA_W-1:0];
                default: ;  // seed goes straight to the LFSR
            endcase
        end
    end

    // partition count clamped to 1..MAX_PARTS; it is also the high-degree mark
    always_comb begin
        if (num_parts_reg == '0)             cfg.np = PC_W'(1);
        else if (num_parts_reg > MAX_PARTS)  cfg.np = PC_W'(MAX_PARTS);
        else                                 cfg.np = num_parts_reg;
        cfg.degree_cutoff = cutoff_reg;
        cfg.alpha         = alpha_reg;
        cfg.lfsr_load     = cfg_wr_en && (cfg_index == CFG_RANDOM_SEED);
        cfg.lfsr_seed     = cfg_wdata[LFSR_W-1:0];
    end

    sgpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .clear_busy (clear_busy),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    sgpa_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_PARTS    (MAX_PARTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
